>>> hw/rtl/decision_tree_classifier_macros.svh
// Assertion macros shared by the decision tree classifier RTL.
`ifndef DECISION_TREE_CLASSIFIER_MACROS_SVH
`define DECISION_TREE_CLASSIFIER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/dtc_pkg.sv
// Shared types and constants of the decision tree classifier.
`timescale 1ns / 1ps
package dtc_pkg;

   localparam int CMD_W      = 2;
   localparam int ADDR_W     = 6;
   localparam int IN_VALUE_W = 32;
   localparam int FSEL_W     = 4;
   localparam int LABEL_W    = 8;

   typedef logic [CMD_W-1:0] dtc_cmd_type;

   localparam dtc_cmd_type CMD_LOAD_FEATURE = 2'd0;
   localparam dtc_cmd_type CMD_LOAD_NODE    = 2'd1;
   localparam dtc_cmd_type CMD_LOAD_LEAF    = 2'd2;
   localparam dtc_cmd_type CMD_CLASSIFY     = 2'd3;

   typedef enum logic [1:0] {
      DTC_IDLE,
      DTC_FEAT,
      DTC_CMP,
      DTC_LEAF
   } dtc_state_type;

endpackage

>>> hw/rtl/decision_tree_classifier.sv
// Decision tree classifier top level: table loading and the level-by-level tree walk.
`timescale 1ns / 1ps
// A word is accepted at a rising edge where start is high and busy is low. The three
// load commands (feature value, tree node, leaf label) write their table in that edge
// and leave busy low, so loads can follow one another every cycle. A classify word
// raises busy and walks the tree from the root: each level reads the node memory
// (feature index and threshold) and then reads the selected feature from the feature
// memory and compares it, because the feature address only becomes known once the
// node word is out of its RAM. After the last level the leaf memory is read, and the
// class label is presented on rsp_class_label with rsp_strobe high for exactly one
// cycle. A new word may be accepted in the strobe cycle itself. The receiver cannot
// stall the result, so it must take the label in that cycle. Loads whose address
// lies beyond their table are dropped silently; a node whose feature index is not
// below NUM_FEATURES compares a feature value of zero. The tables have no reset
// value: classifying through an entry that was never loaded gives an undefined label.
module decision_tree_classifier
   import dtc_pkg::*;
#(
   parameter int TREE_DEPTH   = 6,
   parameter int NUM_FEATURES = 16,
   parameter int VALUE_WIDTH  = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [CMD_W-1:0]             req_cmd,
   input  logic [ADDR_W-1:0]            req_addr,
   input  logic signed [IN_VALUE_W-1:0] req_value,
   input  logic [FSEL_W-1:0]            req_feature_sel,
   input  logic [LABEL_W-1:0]           req_leaf_label,
   output logic                         rsp_strobe,
   output logic [LABEL_W-1:0]           rsp_class_label
);

`include "decision_tree_classifier_macros.svh"

   // Table geometry. Heap numbering: node n has children 2n+1 and 2n+2.
   localparam int NODE_COUNT = (1 << TREE_DEPTH) - 1;
   localparam int LEAF_COUNT = 1 << TREE_DEPTH;
   localparam int FEAT_AW    = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
   localparam int NODE_W     = FSEL_W + VALUE_WIDTH;
   localparam int LVL_W      = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;

   dtc_state_type state_ff, state_in;

   logic [LVL_W-1:0]      level_ff, level_in;
   logic [TREE_DEPTH-1:0] node_ff, node_in;
   logic [TREE_DEPTH-1:0] row_ff, row_in;
   logic                  oor_ff, oor_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [LABEL_W-1:0]    rsp_label_ff, rsp_label_in;

   logic accept;
   assign accept = start && !busy;

   // Incoming value, sign-extended and then fitted to the internal width.
   logic [63:0]            value_ext;
   logic [VALUE_WIDTH-1:0] value_int;
   assign value_ext = {{(64 - IN_VALUE_W){req_value[IN_VALUE_W-1]}}, req_value};
   assign value_int = value_ext[VALUE_WIDTH-1:0];

   // Load addresses, widened or trimmed to each table's address width.
   logic [FEAT_AW+ADDR_W-1:0]    faddr_ext;
   logic [TREE_DEPTH+ADDR_W-1:0] taddr_ext;
   assign faddr_ext = {{FEAT_AW{1'b0}}, req_addr};
   assign taddr_ext = {{TREE_DEPTH{1'b0}}, req_addr};

   // Memory ports.
   logic                   feat_wr_en, feat_rd_en;
   logic [FEAT_AW-1:0]     feat_rd_addr;
   logic [VALUE_WIDTH-1:0] feat_rd_data;

   logic                   node_wr_en, node_rd_en;
   logic [TREE_DEPTH-1:0]  node_rd_addr;
   logic [NODE_W-1:0]      node_rd_data;

   logic                   leaf_wr_en, leaf_rd_en;
   logic [TREE_DEPTH-1:0]  leaf_rd_addr;
   logic [LABEL_W-1:0]     leaf_rd_data;

   // Loads are only taken while the walk is idle, so reads and writes never meet
   // on the same entry and no forwarding is needed.
   assign feat_wr_en = accept && (req_cmd == CMD_LOAD_FEATURE)
                       && (32'(req_addr) < NUM_FEATURES);
   assign node_wr_en = accept && (req_cmd == CMD_LOAD_NODE)
                       && (32'(req_addr) < NODE_COUNT);
   assign leaf_wr_en = accept && (req_cmd == CMD_LOAD_LEAF)
                       && (32'(req_addr) < LEAF_COUNT);

   dtc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(NUM_FEATURES)) u_feature_ram (
      .clock   (clock),
      .wr_en   (feat_wr_en),
      .wr_addr (faddr_ext[FEAT_AW-1:0]),
      .wr_data (value_int),
      .rd_en   (feat_rd_en),
      .rd_addr (feat_rd_addr),
      .rd_data (feat_rd_data)
   );

   dtc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (taddr_ext[TREE_DEPTH-1:0]),
      .wr_data ({req_feature_sel, value_int}),
      .rd_en   (node_rd_en),
      .rd_addr (node_rd_addr),
      .rd_data (node_rd_data)
   );

   dtc_ram #(.WIDTH(LABEL_W), .DEPTH(LEAF_COUNT)) u_leaf_ram (
      .clock   (clock),
      .wr_en   (leaf_wr_en),
      .wr_addr (taddr_ext[TREE_DEPTH-1:0]),
      .wr_data (req_leaf_label),
      .rd_en   (leaf_rd_en),
      .rd_addr (leaf_rd_addr),
      .rd_data (leaf_rd_data)
   );

   // Fields of the node word that is currently out of the node RAM. The read data
   // register holds them through the feature read that follows.
   logic [FSEL_W-1:0]         node_fsel;
   logic signed [VALUE_WIDTH-1:0] node_thr;
   logic [FEAT_AW+FSEL_W-1:0] fsel_ext;
   assign node_fsel = node_rd_data[NODE_W-1 -: FSEL_W];
   assign node_thr  = node_rd_data[VALUE_WIDTH-1:0];
   assign fsel_ext  = {{FEAT_AW{1'b0}}, node_fsel};

   // The comparison: a feature index beyond the store compares zero.
   logic signed [VALUE_WIDTH-1:0] feat_op;
   logic                          go_right;
   assign feat_op  = oor_ff ? '0 : feat_rd_data;
   assign go_right = feat_op > node_thr;

   // Child of the current node and its row on the next level.
   logic [TREE_DEPTH:0]   node_wide;
   logic [TREE_DEPTH:0]   row_wide;
   logic [TREE_DEPTH-1:0] node_nx;
   logic [TREE_DEPTH-1:0] row_nx;
   logic                  last_level;
   assign node_wide  = {node_ff, 1'b1} + (TREE_DEPTH + 1)'(go_right);
   assign row_wide   = {row_ff, go_right};
   assign node_nx    = node_wide[TREE_DEPTH-1:0];
   assign row_nx     = row_wide[TREE_DEPTH-1:0];
   assign last_level = (level_ff == LVL_W'(TREE_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= DTC_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      level_ff     <= level_in;
      node_ff      <= node_in;
      row_ff       <= row_in;
      oor_ff       <= oor_in;
      rsp_label_ff <= rsp_label_in;
   end

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      node_in       = node_ff;
      row_in        = row_ff;
      oor_in        = oor_ff;
      rsp_strobe_in = 1'b0;
      rsp_label_in  = rsp_label_ff;
      node_rd_en    = 1'b0;
      node_rd_addr  = '0;
      feat_rd_en    = 1'b0;
      feat_rd_addr  = fsel_ext[FEAT_AW-1:0];
      leaf_rd_en    = 1'b0;
      leaf_rd_addr  = row_nx;
      case (state_ff)
         DTC_IDLE: begin
            // A classify word starts by reading the root straight away.
            if (accept && (req_cmd == CMD_CLASSIFY)) begin
               node_rd_en = 1'b1;
               level_in   = '0;
               node_in    = '0;
               row_in     = '0;
               state_in   = DTC_FEAT;
            end
         end
         DTC_FEAT: begin
            feat_rd_en = 1'b1;
            oor_in     = !(32'(node_fsel) < NUM_FEATURES);
            state_in   = DTC_CMP;
         end
         DTC_CMP: begin
            if (last_level) begin
               leaf_rd_en = 1'b1;
               state_in   = DTC_LEAF;
            end else begin
               node_rd_en   = 1'b1;
               node_rd_addr = node_nx;
               node_in      = node_nx;
               row_in       = row_nx;
               level_in     = level_ff + 1'b1;
               state_in     = DTC_FEAT;
            end
         end
         DTC_LEAF: begin
            rsp_strobe_in = 1'b1;
            rsp_label_in  = leaf_rd_data;
            state_in      = DTC_IDLE;
         end
         default: begin
            state_in = DTC_IDLE;
         end
      endcase
   end

   assign busy            = (state_ff != DTC_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_class_label = rsp_label_ff;

   // A result only ever follows the leaf read.
   `DTC_ASSERT_NOW(a_strobe_after_leaf, clock, reset, rsp_strobe, $past(state_ff) == DTC_LEAF, "result without a leaf read")
   // The strobe cycle is idle, so the next word can be taken alongside it.
   `DTC_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy, "busy during the result cycle")
   // An accepted classify word starts the walk at once.
   `DTC_ASSERT_NEXT(a_classify_starts, clock, reset, accept && (req_cmd == CMD_CLASSIFY), state_ff == DTC_FEAT, "classify did not start the walk")
   // The level counter never runs past the last level of the tree.
   `DTC_ASSERT_NOW(a_level_range, clock, reset, state_ff == DTC_CMP, level_ff <= LVL_W'(TREE_DEPTH - 1), "walk ran past the tree depth")

endmodule

>>> hw/rtl/dtc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module dtc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
